@@ rtl/dng_hc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the DNG header check with FNV-1a 64 hash.
// Holds constants, the directory scan state type and the step/hash functions.
// No dependencies.
package dng_hc_pkg;

    localparam logic [15:0] TIFF_MAGIC        = 16'd42;
    localparam logic [15:0] DNG_VERSION_TAG   = 16'd50706;
    localparam logic [63:0] FNV_BASIS         = 64'hcbf2_9ce4_8422_2325;
    localparam logic [7:0]  ORDER_LITTLE_CHAR = 8'h49;  // 'I'
    localparam logic [7:0]  ORDER_BIG_CHAR    = 8'h4D;  // 'M'
    localparam logic [3:0]  ENTRY_LAST        = 4'd11;  // last byte of a 12-byte entry
    localparam int          HDR_STORED        = 7;      // header bytes kept before decode

    typedef enum logic [1:0] {
        IFD_WAIT,
        IFD_COUNT,
        IFD_ENTRIES
    } ifd_phase_t;

    typedef struct packed {
        ifd_phase_t  phase;
        logic [7:0]  partial;
        logic [15:0] total;
        logic [15:0] seen;
        logic [3:0]  ent_pos;
        logic        tag_found;
    } ifd_state_t;

    localparam ifd_state_t IFD_RESET = '{
        phase:     IFD_WAIT,
        partial:   8'd0,
        total:     16'd0,
        seen:      16'd0,
        ent_pos:   4'd0,
        tag_found: 1'b0
    };

    function automatic logic [15:0] join16(input logic [7:0] first,
                                           input logic [7:0] second,
                                           input logic little);
        return little ? {second, first} : {first, second};
    endfunction

    // Multiply by the FNV prime 2^40 + 2^8 + 0xb3 as a shift-add.
    function automatic logic [63:0] fnv_mult(input logic [63:0] x);
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    // Advance the directory scan by one byte at consecutive file positions.
    function automatic ifd_state_t ifd_step(input ifd_state_t s,
                                            input logic at_off,
                                            input logic [7:0] b,
                                            input logic little);
        ifd_state_t n;
        n = s;
        unique case (s.phase)
            IFD_WAIT:
            begin
                if (at_off)
                begin
                    n.partial = b;
                    n.phase   = IFD_COUNT;
                end
            end
            IFD_COUNT:
            begin
                n.total = join16(s.partial, b, little);
                n.phase = IFD_ENTRIES;
            end
            IFD_ENTRIES:
            begin
                if (s.seen < s.total)
                begin
                    if (s.ent_pos == 4'd0)
                        n.partial = b;
                    else if (s.ent_pos == 4'd1 &&
                             join16(s.partial, b, little) == DNG_VERSION_TAG)
                        n.tag_found = 1'b1;
                    if (s.ent_pos == ENTRY_LAST)
                    begin
                        n.seen    = s.seen + 16'd1;
                        n.ent_pos = 4'd0;
                    end
                    else
                    begin
                        n.ent_pos = s.ent_pos + 4'd1;
                    end
                end
            end
            default:
            begin
                n = s;
            end
        endcase
        return n;
    endfunction

endpackage

@@ rtl/dng_header_check_fnv_hash.sv @@
`timescale 1ns / 1ps
// DNG header check with FNV-1a 64 hash: top level.
// Depends on dng_hc_pkg (constants, scan state type, hash and scan functions).
//
// Throughput: one byte per cycle while in_ready is high (input stalls only while
// the snapshot is full and the output register is held); the FNV shift-add
// feeding the running hash register sets the cycle. The result of a file goes
// through the final snapshot, then the length check into the output register.
// Reset (rst_n low, asynchronous) empties the pipeline and resets scan state and hash.
module dng_header_check_fnv_hash
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_dng,
    output logic [63:0] file_length,
    output logic [63:0] hash_value
);

    // ------------------------------------------------------------------
    // Per-file state
    // ------------------------------------------------------------------
    logic [63:0]            hash_reg, hash_next, hash_upd;
    logic [63:0]            pos_reg, pos_next, pos_upd;
    logic [7:0]             hdr_reg [0:dng_hc_pkg::HDR_STORED-1];
    logic [7:0]             hdr_next [0:dng_hc_pkg::HDR_STORED-1];
    logic                   hv_reg, hv_next, hv_upd;
    logic                   little_reg, little_next, little_upd;
    logic [31:0]            off_reg, off_next, off_upd;
    dng_hc_pkg::ifd_state_t ifd_reg, ifd_next, ifd_upd;

    // Final snapshot of a file, waiting for the length check
    logic                   snap_valid_reg, snap_valid_next;
    logic [63:0]            snap_len_reg;
    logic [63:0]            snap_hash_reg;
    logic                   snap_hv_reg;
    logic                   snap_tag_reg;
    logic [15:0]            snap_total_reg;
    logic [31:0]            snap_off_reg;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic                   is_dng_reg;
    logic [63:0]            file_length_reg;
    logic [63:0]            hash_value_reg;

    // Handshake
    logic accept;
    logic snap_move;

    // Position decode
    logic pos_sat;
    logic pos_in_hdr;
    logic pos_is_last_hdr;
    logic [2:0] pos_lo;

    // Header decode on the eighth byte
    logic [7:0]             hdr_all [0:7];
    logic                   dec_ii;
    logic                   dec_mm;
    logic                   dec_valid;
    logic [31:0]            dec_off;
    dng_hc_pkg::ifd_state_t scan [0:8];
    dng_hc_pkg::ifd_state_t ifd_stream;

    // Length check
    logic [33:0] need;
    logic        short_file;
    logic        fits;

    // ------------------------------------------------------------------
    // Handshake: the snapshot stage only blocks input while it is full and
    // cannot drain into the output register.
    // ------------------------------------------------------------------
    assign snap_move = snap_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !snap_valid_reg || snap_move;
    assign accept    = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Position classes. Saturated position stops header and directory work.
    // ------------------------------------------------------------------
    assign pos_sat         = &pos_reg;
    assign pos_lo          = pos_reg[2:0];
    assign pos_in_hdr      = (pos_reg[63:3] == 61'd0) && (pos_lo != 3'd7);
    assign pos_is_last_hdr = (pos_reg[63:3] == 61'd0) && (pos_lo == 3'd7);

    // ------------------------------------------------------------------
    // Header decode: bytes 0..6 come from the store, byte 7 is on the input.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < dng_hc_pkg::HDR_STORED; k++)
            hdr_all[k] = hdr_reg[k];
        hdr_all[7] = data_byte;
    end

    assign dec_ii = (hdr_reg[0] == dng_hc_pkg::ORDER_LITTLE_CHAR) &&
                    (hdr_reg[1] == dng_hc_pkg::ORDER_LITTLE_CHAR);
    assign dec_mm = (hdr_reg[0] == dng_hc_pkg::ORDER_BIG_CHAR) &&
                    (hdr_reg[1] == dng_hc_pkg::ORDER_BIG_CHAR);
    assign dec_valid = (dec_ii || dec_mm) &&
                       (dng_hc_pkg::join16(hdr_reg[2], hdr_reg[3], dec_ii) ==
                        dng_hc_pkg::TIFF_MAGIC);
    assign dec_off = dec_ii ? {data_byte, hdr_reg[6], hdr_reg[5], hdr_reg[4]}
                            : {hdr_reg[4], hdr_reg[5], hdr_reg[6], data_byte};

    // Replay the eight header bytes through the directory scan, in case the
    // count or the first tag lies inside the header.
    always_comb
    begin
        scan[0] = ifd_reg;
        for (int k = 0; k < 8; k++)
            scan[k+1] = dng_hc_pkg::ifd_step(scan[k], dec_off == 32'(k),
                                             hdr_all[k], dec_ii);
    end

    // Streaming directory scan for bytes past the header
    assign ifd_stream = dng_hc_pkg::ifd_step(ifd_reg, pos_reg == {32'd0, off_reg},
                                             data_byte, little_reg);

    // ------------------------------------------------------------------
    // Next state for one accepted byte; a last byte hands the updated values
    // to the snapshot and restarts the file state.
    // ------------------------------------------------------------------
    always_comb
    begin
        hash_upd   = hash_reg;
        pos_upd    = pos_reg;
        hv_upd     = hv_reg;
        little_upd = little_reg;
        off_upd    = off_reg;
        ifd_upd    = ifd_reg;
        for (int k = 0; k < dng_hc_pkg::HDR_STORED; k++)
            hdr_next[k] = hdr_reg[k];

        if (accept)
        begin
            hash_upd = dng_hc_pkg::fnv_mult(hash_reg ^ {56'd0, data_byte});
            if (!pos_sat)
            begin
                pos_upd = pos_reg + 64'd1;
                if (pos_in_hdr)
                begin
                    for (int k = 0; k < dng_hc_pkg::HDR_STORED; k++)
                        if (pos_lo == 3'(k))
                            hdr_next[k] = data_byte;
                end
                else if (pos_is_last_hdr)
                begin
                    little_upd = dec_ii;
                    hv_upd     = dec_valid;
                    off_upd    = dec_off;
                    ifd_upd    = scan[8];
                end
                else
                begin
                    ifd_upd = ifd_stream;
                end
            end
        end

        hash_next   = hash_upd;
        pos_next    = pos_upd;
        hv_next     = hv_upd;
        little_next = little_upd;
        off_next    = off_upd;
        ifd_next    = ifd_upd;

        if (accept && last_byte)
        begin
            hash_next   = dng_hc_pkg::FNV_BASIS;
            pos_next    = 64'd0;
            hv_next     = 1'b0;
            little_next = 1'b0;
            off_next    = 32'd0;
            ifd_next    = dng_hc_pkg::IFD_RESET;
            for (int k = 0; k < dng_hc_pkg::HDR_STORED; k++)
                hdr_next[k] = 8'd0;
        end
    end

    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        if (accept && last_byte)
            snap_valid_next = 1'b1;
        else if (snap_move)
            snap_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (snap_move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // ------------------------------------------------------------------
    // Length check: the directory must fit, count*12 + offset + 2 <= length.
    // Files shorter than the header report all zeros.
    // ------------------------------------------------------------------
    assign need = 34'({snap_total_reg, 3'b000}) + 34'({snap_total_reg, 2'b00}) +
                  34'(snap_off_reg) + 34'd2;
    assign short_file = (snap_len_reg[63:3] == 61'd0);
    assign fits       = snap_len_reg >= 64'(need);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg       <= dng_hc_pkg::FNV_BASIS;
            pos_reg        <= 64'd0;
            hv_reg         <= 1'b0;
            little_reg     <= 1'b0;
            off_reg        <= 32'd0;
            ifd_reg        <= dng_hc_pkg::IFD_RESET;
            for (int k = 0; k < dng_hc_pkg::HDR_STORED; k++)
                hdr_reg[k] <= 8'd0;
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hash_reg       <= hash_next;
            pos_reg        <= pos_next;
            hv_reg         <= hv_next;
            little_reg     <= little_next;
            off_reg        <= off_next;
            ifd_reg        <= ifd_next;
            for (int k = 0; k < dng_hc_pkg::HDR_STORED; k++)
                hdr_reg[k] <= hdr_next[k];
            snap_valid_reg <= snap_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload: capture the finished file, then the checked result
    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            snap_len_reg   <= pos_upd;
            snap_hash_reg  <= hash_upd;
            snap_hv_reg    <= hv_upd;
            snap_tag_reg   <= ifd_upd.tag_found;
            snap_total_reg <= ifd_upd.total;
            snap_off_reg   <= off_upd;
        end
        if (snap_move)
        begin
            is_dng_reg      <= !short_file && snap_hv_reg && fits && snap_tag_reg;
            file_length_reg <= short_file ? 64'd0 : snap_len_reg;
            hash_value_reg  <= short_file ? 64'd0 : snap_hash_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_dng      = is_dng_reg;
    assign file_length = file_length_reg;
    assign hash_value  = hash_value_reg;

endmodule
